// ===== sv/button_click_classifier_defines.svh =====
// Assertion macros used by the checker of the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// A condition that must hold at every rising edge outside reset.
`define BCC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// A condition that, once true, must be followed by another in the next cycle.
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bcc_pkg.sv =====
// Package with the sizes, register indexes and mode codes of the button click classifier.
package bcc_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int COUNT_WIDTH = 16;
   localparam int MASK_WIDTH  = 4;
   localparam int CFG_WIDTH   = 16;
   localparam int IDX_WIDTH   = 2;

   // Width used for timeout compares so that a period above the counter's
   // saturation value never matches.
   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   // Width of the internal event vectors: covers every button and every mask bit.
   localparam int EV_WIDTH  = (NUM_BUTTONS > MASK_WIDTH) ? NUM_BUTTONS : MASK_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CFG_WIDTH-1:0]   period_type;
   typedef logic [MASK_WIDTH-1:0]  mask_type;
   typedef logic [IDX_WIDTH-1:0]   index_type;

   localparam count_type COUNT_MAX = '1;

   // Configuration register indexes.
   localparam index_type REG_RELEASE_WAIT  = 2'd0;
   localparam index_type REG_LONG_PRESS    = 2'd1;
   localparam index_type REG_DOUBLE_WINDOW = 2'd2;

   localparam period_type RELEASE_WAIT_RESET  = 16'd100;
   localparam period_type LONG_PRESS_RESET    = 16'd1000;
   localparam period_type DOUBLE_WINDOW_RESET = 16'd400;

   typedef enum logic [2:0] {
      MODE_WAIT_RELEASE = 3'd0,
      MODE_WAIT_CLICK   = 3'd1,
      MODE_SHORT        = 3'd2,
      MODE_SECOND       = 3'd3,
      MODE_LONG         = 3'd4
   } mode_type;

endpackage

// ===== sv/button_click_classifier.sv =====
// Top level of the button click classifier: per-button click state machines and result register.
//
// Every request is one tick carrying the debounced pressed level of each button
// (req_pressed_mask, bit n for button n). Each button keeps its own mode and a
// saturating elapsed-tick counter, and the tick is turned into five event masks:
// first press, short release, long press, double press and long release.
//
// A request is accepted when req_valid and req_ready are both high. Its result
// appears on the rsp_ ports in the next cycle and stays there until rsp_valid
// and rsp_ready are both high. Unless the receiver stalls, one request is taken
// every cycle: the button state is updated at the accept edge and the events go
// into the result register, so the whole update is one short pass of
// compare-and-select logic per button.
//
// When the receiver stalls, req_ready falls only while a result is held and
// rsp_ready is low; as soon as the held result is taken a new request may enter
// in the same cycle.
//
// Reset puts every button into its wait-for-release mode with a zero counter,
// empties the result register and loads the three periods with their defaults.
// The configuration channel (csr_) is always ready; a write to an index past the
// last register is accepted and ignored.
module button_click_classifier (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bcc_pkg::mask_type       req_pressed_mask,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bcc_pkg::mask_type       rsp_first_press_mask,
   output bcc_pkg::mask_type       rsp_short_release_mask,
   output bcc_pkg::mask_type       rsp_long_press_mask,
   output bcc_pkg::mask_type       rsp_double_press_mask,
   output bcc_pkg::mask_type       rsp_long_release_mask,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  bcc_pkg::index_type      csr_index,
   input  bcc_pkg::period_type     csr_data
);
   import bcc_pkg::*;

   // Configuration registers.
   period_type release_wait_ff;
   period_type long_press_ff;
   period_type double_window_ff;

   // Per-button state.
   mode_type  mode_ff    [NUM_BUTTONS];
   mode_type  mode_in    [NUM_BUTTONS];
   count_type elapsed_ff [NUM_BUTTONS];
   count_type elapsed_in [NUM_BUTTONS];

   // Result register.
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   mask_type first_ff, short_ff, long_ff, double_ff, lrel_ff;

   // Events of the current tick, one bit per button.
   logic [EV_WIDTH-1:0] ev_first, ev_short, ev_long, ev_double, ev_lrel;

   logic accept;

   assign csr_ready = 1'b1;

   // A new request may enter whenever the result register is empty or is being
   // drained in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_wait_ff  <= RELEASE_WAIT_RESET;
         long_press_ff    <= LONG_PRESS_RESET;
         double_window_ff <= DOUBLE_WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_RELEASE_WAIT:  release_wait_ff  <= csr_data;
            REG_LONG_PRESS:    long_press_ff    <= csr_data;
            REG_DOUBLE_WINDOW: double_window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // One state machine per button. Every button's update is independent of the
   // others, so the generate loop simply replicates the same small slice.
   for (genvar n = 0; n < EV_WIDTH; n++) begin : g_button
      if (n < NUM_BUTTONS) begin : g_live
         logic      pressed;
         count_type e_inc;
         logic      to_release, to_long, to_double;

         // Buttons past the mask width always read as released.
         if (n < MASK_WIDTH) begin : g_in
            assign pressed = req_pressed_mask[n];
         end else begin : g_none
            assign pressed = 1'b0;
         end

         // The counter advances first, then the machine looks at the new value.
         assign e_inc = (elapsed_ff[n] == COUNT_MAX) ? elapsed_ff[n]
                                                     : elapsed_ff[n] + 1'b1;

         // Timeouts are compared at a common width so that a period larger
         // than the counter can reach is never met.
         assign to_release = CMP_WIDTH'(e_inc) >= CMP_WIDTH'(release_wait_ff);
         assign to_long    = CMP_WIDTH'(e_inc) >= CMP_WIDTH'(long_press_ff);
         assign to_double  = CMP_WIDTH'(e_inc) >= CMP_WIDTH'(double_window_ff);

         // Next state.
         always_comb begin
            mode_in[n]    = mode_ff[n];
            elapsed_in[n] = e_inc;
            unique case (mode_ff[n])
               MODE_WAIT_RELEASE: begin
                  if (pressed) begin
                     elapsed_in[n] = '0;
                  end else if (to_release) begin
                     mode_in[n] = MODE_WAIT_CLICK;
                  end
               end
               MODE_WAIT_CLICK: begin
                  if (pressed) begin
                     elapsed_in[n] = '0;
                     mode_in[n]    = MODE_SHORT;
                  end
               end
               MODE_SHORT: begin
                  if (!pressed) begin
                     mode_in[n] = MODE_SECOND;
                  end else if (to_long) begin
                     mode_in[n] = MODE_LONG;
                  end
               end
               MODE_SECOND: begin
                  if (to_double) begin
                     mode_in[n] = MODE_WAIT_CLICK;
                  end else if (pressed) begin
                     elapsed_in[n] = '0;
                     mode_in[n]    = MODE_WAIT_RELEASE;
                  end
               end
               MODE_LONG: begin
                  if (!pressed) begin
                     mode_in[n] = MODE_WAIT_CLICK;
                  end
               end
               default: begin
                  // Corrupted mode code: start over from wait-for-release.
                  elapsed_in[n] = '0;
                  mode_in[n]    = MODE_WAIT_RELEASE;
               end
            endcase
         end

         // Events of this tick.
         always_comb begin
            ev_first[n]  = 1'b0;
            ev_short[n]  = 1'b0;
            ev_long[n]   = 1'b0;
            ev_double[n] = 1'b0;
            ev_lrel[n]   = 1'b0;
            unique case (mode_ff[n])
               MODE_WAIT_CLICK: ev_first[n]  = pressed;
               MODE_SHORT: begin
                  ev_short[n] = !pressed;
                  ev_long[n]  = pressed && to_long;
               end
               MODE_SECOND:     ev_double[n] = !to_double && pressed;
               MODE_LONG:       ev_lrel[n]   = !pressed;
               default: ;
            endcase
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               mode_ff[n]    <= MODE_WAIT_RELEASE;
               elapsed_ff[n] <= '0;
            end else if (accept) begin
               mode_ff[n]    <= mode_in[n];
               elapsed_ff[n] <= elapsed_in[n];
            end
         end
      end else begin : g_pad
         // Mask bits with no button behind them never report.
         assign ev_first[n]  = 1'b0;
         assign ev_short[n]  = 1'b0;
         assign ev_long[n]   = 1'b0;
         assign ev_double[n] = 1'b0;
         assign ev_lrel[n]   = 1'b0;
      end
   end

   // The result register fills on an accepted request and empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset; it is loaded with every accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff  <= ev_first[MASK_WIDTH-1:0];
         short_ff  <= ev_short[MASK_WIDTH-1:0];
         long_ff   <= ev_long[MASK_WIDTH-1:0];
         double_ff <= ev_double[MASK_WIDTH-1:0];
         lrel_ff   <= ev_lrel[MASK_WIDTH-1:0];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_first_press_mask   = first_ff;
   assign rsp_short_release_mask = short_ff;
   assign rsp_long_press_mask    = long_ff;
   assign rsp_double_press_mask  = double_ff;
   assign rsp_long_release_mask  = lrel_ff;

endmodule

// ===== sv/bcc_checker.sv =====
// Port-level checker for the button click classifier and its bind statement.
`include "button_click_classifier_defines.svh"

module bcc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bcc_pkg::mask_type   rsp_first_press_mask,
   input bcc_pkg::mask_type   rsp_short_release_mask,
   input bcc_pkg::mask_type   rsp_long_press_mask,
   input bcc_pkg::mask_type   rsp_double_press_mask,
   input bcc_pkg::mask_type   rsp_long_release_mask
);
   import bcc_pkg::*;

   mask_type                  any_event;
   logic                      overlap;
   logic                      stall;
   logic [5*MASK_WIDTH-1:0]   rsp_all;

   // A button is in exactly one mode per tick, so at most one event per button.
   assign any_event = rsp_first_press_mask | rsp_short_release_mask | rsp_long_press_mask |
                      rsp_double_press_mask | rsp_long_release_mask;
   assign overlap   = ($countones(rsp_first_press_mask) + $countones(rsp_short_release_mask) +
                       $countones(rsp_long_press_mask) + $countones(rsp_double_press_mask) +
                       $countones(rsp_long_release_mask)) != $countones(any_event);

   // A held result must keep every mask unchanged until it is taken.
   assign stall   = rsp_valid && !rsp_ready;
   assign rsp_all = {rsp_first_press_mask, rsp_short_release_mask, rsp_long_press_mask,
                     rsp_double_press_mask, rsp_long_release_mask};

   `BCC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result after reset")
   `BCC_ASSERT_NEXT(a_accept, clock, reset, req_valid && req_ready, rsp_valid, "request lost")
   `BCC_ASSERT_ALWAYS(a_ready_empty, clock, reset, rsp_valid || req_ready, "stalled while empty")
   `BCC_ASSERT_ALWAYS(a_one_event, clock, reset, !rsp_valid || !overlap, "two events per button")
   `BCC_ASSERT_NEXT(a_hold, clock, reset, stall, rsp_valid && $stable(rsp_all), "result changed")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the button click classifier, with its own event predictor.
module testbench;
   import bcc_pkg::*;

   // Each side idles in about this many cycles out of a hundred.
   localparam int IDLE_PERCENT    = 31;
   // Length of the long receiver hold-off that fills the block up.
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles with no handshake on any channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 2000;
   // Extra cycles after the last result, so that nothing is still in flight.
   localparam int DRAIN_CYCLES    = 3;
   // The register index past the last register. Writes to it must be ignored.
   localparam index_type REG_UNUSED = 2'd3;

   // The five event masks that one tick produces.
   typedef struct packed {
      mask_type first_press;
      mask_type short_release;
      mask_type long_press;
      mask_type double_press;
      mask_type long_release;
   } tick_events_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   mask_type   req_pressed_mask = '0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   mask_type   rsp_first_press_mask;
   mask_type   rsp_short_release_mask;
   mask_type   rsp_long_press_mask;
   mask_type   rsp_double_press_mask;
   mask_type   rsp_long_release_mask;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   index_type  csr_index        = '0;
   period_type csr_data         = '0;

   button_click_classifier u_top (.*);

   always #4 clock = ~clock;

   // Predicted state of the block: the three periods and each button's mode and
   // saturating tick counter, plus the events still waiting to come out.
   period_type      release_wait_period;
   period_type      long_press_period;
   period_type      double_window_period;
   mode_type        button_mode [NUM_BUTTONS];
   count_type       button_elapsed [NUM_BUTTONS];
   tick_events_type tick_events_q [$];

   // Run-wide bookkeeping.
   int error_count = 0;
   int ticks_checked = 0;
   int register_writes = 0;
   int first_presses = 0;
   int short_releases = 0;
   int long_presses = 0;
   int double_presses = 0;
   int long_releases = 0;

   // Knobs that the test tasks turn on the two sides of the block.
   bit          steady_flow      = 1'b0;
   logic        hold_off_request = 1'b0;
   int unsigned hold_left        = 0;
   int unsigned quiet_cycles     = 0;

   // A period runs out once the counter has reached it. The compare is done wide so
   // that it stays unsigned whatever the two widths are.
   function automatic bit timed_out(input count_type elapsed, input period_type period);
      return 32'(elapsed) >= 32'(period);
   endfunction

   // Advance every button by one tick and return the events of that tick. The counter
   // moves first, saturating at its top value, and only then is the mode looked at,
   // so the first tick after a restart sees a count of one.
   function automatic tick_events_type classify_tick(input mask_type pressed);
      tick_events_type ev;
      count_type       e;
      mode_type        m;
      bit              down;
      ev = '0;
      for (int n = 0; n < NUM_BUTTONS; n++) begin
         down = (n < MASK_WIDTH) && pressed[n];
         e = button_elapsed[n];
         m = button_mode[n];
         if (e != COUNT_MAX) e = e + 1'b1;
         case (m)
            MODE_WAIT_RELEASE: begin
               // Any press starts the quiet time over.
               if (down) e = '0;
               else if (timed_out(e, release_wait_period)) m = MODE_WAIT_CLICK;
            end
            MODE_WAIT_CLICK: begin
               if (down) begin
                  ev.first_press[n] = 1'b1;
                  e = '0;
                  m = MODE_SHORT;
               end
            end
            MODE_SHORT: begin
               // The counter keeps running from the first press into the window.
               if (!down) begin
                  ev.short_release[n] = 1'b1;
                  m = MODE_SECOND;
               end else if (timed_out(e, long_press_period)) begin
                  ev.long_press[n] = 1'b1;
                  m = MODE_LONG;
               end
            end
            MODE_SECOND: begin
               // The window closing wins over a press on the same tick.
               if (timed_out(e, double_window_period)) begin
                  m = MODE_WAIT_CLICK;
               end else if (down) begin
                  ev.double_press[n] = 1'b1;
                  e = '0;
                  m = MODE_WAIT_RELEASE;
               end
            end
            MODE_LONG: begin
               if (!down) begin
                  ev.long_release[n] = 1'b1;
                  m = MODE_WAIT_CLICK;
               end
            end
            default: begin
               e = '0;
               m = MODE_WAIT_RELEASE;
            end
         endcase
         button_elapsed[n] = e;
         button_mode[n] = m;
      end
      return ev;
   endfunction

   function automatic void check_mask(input string field, input mask_type want,
                                      input mask_type got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         error_count++;
      end
   endfunction

   // Monitor. Everything is sampled at the rising edge, before the block's own
   // updates of that edge land. A result is checked against the oldest prediction,
   // a register write changes the predicted periods, and an accepted request is run
   // through the predictor. A write and a request never share an edge.
   always @(posedge clock) begin
      tick_events_type want;
      if (reset) begin
         release_wait_period = RELEASE_WAIT_RESET;
         long_press_period = LONG_PRESS_RESET;
         double_window_period = DOUBLE_WINDOW_RESET;
         for (int n = 0; n < NUM_BUTTONS; n++) begin
            button_mode[n] = MODE_WAIT_RELEASE;
            button_elapsed[n] = '0;
         end
         tick_events_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tick_events_q.size() == 0) begin
               $error("Result arrived with no request outstanding");
               error_count++;
            end else begin
               want = tick_events_q.pop_front();
               check_mask("first_press_mask", want.first_press, rsp_first_press_mask);
               check_mask("short_release_mask", want.short_release, rsp_short_release_mask);
               check_mask("long_press_mask", want.long_press, rsp_long_press_mask);
               check_mask("double_press_mask", want.double_press, rsp_double_press_mask);
               check_mask("long_release_mask", want.long_release, rsp_long_release_mask);
               ticks_checked++;
               first_presses += $countones(want.first_press);
               short_releases += $countones(want.short_release);
               long_presses += $countones(want.long_press);
               double_presses += $countones(want.double_press);
               long_releases += $countones(want.long_release);
            end
         end
         if (csr_valid && csr_ready) begin
            register_writes++;
            case (csr_index)
               REG_RELEASE_WAIT: release_wait_period = csr_data;
               REG_LONG_PRESS: long_press_period = csr_data;
               REG_DOUBLE_WINDOW: double_window_period = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) tick_events_q.push_back(classify_tick(req_pressed_mask));
      end
   end

   // Receiver. It normally drops ready at random. A hold-off request makes it keep
   // ready low for a long count of its own, and steady flow keeps ready high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_request) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog. Any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, tick_events_q.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one tick request and hold it until it is taken. Valid is dropped only
   // during a random gap, so back-to-back requests keep it high.
   task automatic send_tick(input mask_type pressed);
      while (!steady_flow && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pressed_mask <= pressed;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Stop offering requests and wait until every predicted result has been taken,
   // then a few more cycles so that nothing is still in flight.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tick_events_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Registers are only written with the block idle.
   task automatic write_register(input index_type index, input period_type value);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_periods(input period_type release_wait, input period_type long_press,
                              input period_type double_window);
      write_register(REG_RELEASE_WAIT, release_wait);
      write_register(REG_LONG_PRESS, long_press);
      write_register(REG_DOUBLE_WINDOW, double_window);
   endtask

   // How long a button keeps its level: short bounces, anything up to the cap, or a
   // value close to one of the periods so that the timeouts are hit on both sides.
   function automatic int unsigned pick_run_length(input int unsigned max_run);
      int unsigned target;
      case ($urandom_range(3))
         0: target = $urandom_range(3);
         1: target = $urandom_range(max_run);
         2: target = release_wait_period;
         default: target = $urandom_range(1) ? long_press_period : double_window_period;
      endcase
      target = target + $urandom_range(4);
      target = (target > 2) ? target - 2 : 0;
      return (target > max_run) ? max_run : target;
   endfunction

   // Well-formed button activity: each button alternates between held and released
   // runs of chosen length. Some ticks are replaced by random masks as noise.
   task automatic drive_click_runs(input int unsigned ticks, input int unsigned max_run,
                                   input int unsigned noise_percent);
      mask_type    level;
      int unsigned run_left [NUM_BUTTONS];
      level = mask_type'($urandom_range(15));
      foreach (run_left[n]) run_left[n] = $urandom_range(max_run);
      repeat (ticks) begin
         for (int n = 0; n < NUM_BUTTONS; n++) begin
            if (run_left[n] == 0) begin
               level[n] = ~level[n];
               run_left[n] = pick_run_length(max_run);
            end else begin
               run_left[n]--;
            end
         end
         if ($urandom_range(99) < noise_percent) send_tick(mask_type'($urandom_range(15)));
         else send_tick(level);
      end
   endtask

   // The reset periods are used as they come out of reset, with clicks and double
   // presses timed around the release wait and the window. A long press at the
   // reset period needs more ticks than this stretch has.
   task automatic test_default_periods();
      drive_click_runs(500, 450, 5);
   endtask

   // With the release wait at the counter's top value, a button that sits in its
   // release wait stays there with no event until its counter reaches the top value.
   // This stretch runs with no idling on either side.
   task automatic test_top_release_wait();
      steady_flow = 1'b1;
      // Tiny periods bring every button back to wait-click within a few ticks.
      set_periods(16'd2, 16'd4, 16'd3);
      repeat (8) send_tick('0);
      // First press, short release and double press put every button into the wait.
      send_tick('1);
      send_tick('0);
      send_tick('1);
      write_register(REG_RELEASE_WAIT, COUNT_MAX);
      repeat (300) send_tick('0);
      repeat (3) send_tick('1);
      send_tick('0);
      steady_flow = 1'b0;
   endtask

   // A hand-made sequence at tiny periods, then the zero and top periods.
   task automatic test_directed_sequence();
      mask_type small_script [$] = '{
         // Settle every button into wait-click.
         4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
         // All buttons start a click.
         4'b1111,
         // Buttons 0 and 2 let go early and get a short release.
         4'b1010,
         // Button 0 presses again inside the window.
         4'b1011,
         // Button 0 presses in its release wait, which restarts it. Button 3 lets go.
         4'b0011,
         // Button 1 reaches a long press. Button 3 presses as its window closes.
         4'b1010,
         // Button 1 lets go after the long press.
         4'b0000,
         4'b1111
      };
      mask_type zero_script [$] = '{4'b0000, 4'b1111, 4'b1111, 4'b0000, 4'b1111,
                                    4'b0000, 4'b0000, 4'b1111};
      set_periods(16'd2, 16'd4, 16'd3);
      foreach (small_script[i]) send_tick(small_script[i]);
      // With zero periods every timeout holds at once.
      set_periods('0, '0, '0);
      foreach (zero_script[i]) send_tick(zero_script[i]);
      // With top periods nothing times out: a double press is always accepted.
      set_periods('1, '1, '1);
      send_tick(4'b1111);
      send_tick(4'b0000);
      send_tick(4'b1111);
      send_tick(4'b0000);
   endtask

   // A write past the last register must leave all three periods alone.
   task automatic test_unused_index();
      set_periods(16'd5, 16'd12, 16'd8);
      write_register(REG_UNUSED, period_type'($urandom_range(16'hFFFF)));
      drive_click_runs(60, 30, 0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the
   // block fills up and pushes back on its input.
   task automatic test_backpressure();
      set_periods(16'd3, 16'd10, 16'd6);
      hold_off_request <= 1'b1;
      @(posedge clock);
      hold_off_request <= 1'b0;
      drive_click_runs(100, 20, 10);
   endtask

   function automatic period_type random_period();
      return ($urandom_range(9) == 0) ? period_type'(0) : period_type'($urandom_range(1, 24));
   endfunction

   // Random phases, each with its own periods: the extremes first, then mixes.
   // One phase is about half noise to break up the click sequences.
   task automatic test_random_phases();
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_periods('0, '0, '0);
            1: set_periods('1, '1, '1);
            2: set_periods('0, '1, random_period());
            3: set_periods('1, random_period(), '0);
            default: set_periods(random_period(), random_period(), random_period());
         endcase
         drive_click_runs(60, 40, (phase == 4) ? 50 : 8);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_periods();
      test_top_release_wait();
      test_directed_sequence();
      test_unused_index();
      test_backpressure();
      test_random_phases();
      wait_until_drained();
      $display("Checked %0d ticks over %0d register writes, one long receiver hold-off",
               ticks_checked, register_writes);
      $display("Events: %0d first, %0d short release, %0d long, %0d double, %0d long release",
               first_presses, short_releases, long_presses, double_presses, long_releases);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
